@@ hw/rtl/rlec_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rlec_pkg;

    // Field widths
    localparam int KIND_W  = 3;
    localparam int MODE_W  = 3;
    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 24;
    localparam int HALF_W  = 8;
    localparam int CNT_W8  = 8;
    localparam int HOLD_W  = 16;
    localparam int PHASE_W = 2;
    localparam int WAIT_W  = 3;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_PULSE_COLOR   = 2'd0;
    localparam logic [1:0] REG_RAINBOW_TICKS = 2'd1;
    localparam logic [1:0] REG_PULSE_TICKS   = 2'd2;

    localparam logic [COLOR_W-1:0] PULSE_COLOR_RST   = '0;
    localparam logic [HOLD_W-1:0]  RAINBOW_TICKS_RST = 16'd10;
    localparam logic [HOLD_W-1:0]  PULSE_TICKS_RST   = 16'd10;

    // History depth default
    localparam int HISTORY_DEPTH_DEF = 8;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK        = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SET_MODE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PREV_MODE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SET_COLOR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SET_565     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_OFF         = 3'd5;
    localparam logic [KIND_W-1:0] KIND_OVERRIDE    = 3'd6;
    localparam logic [KIND_W-1:0] KIND_BLINK       = 3'd7;

    // Modes
    localparam logic [MODE_W-1:0] MODE_MANUAL   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RAINBOW  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PULSING  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BLINK    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OVERRIDE = 3'd4;

    // Effect timing
    localparam logic [WAIT_W-1:0]  BLINK_START_WAIT = 3'd5;
    localparam logic [CHAN_W-1:0]  RAMP_MAX         = 8'd255;
    localparam logic [CHAN_W-1:0]  RAMP_LAST_STEP   = 8'd254;
    localparam logic [PHASE_W-1:0] RAINBOW_LAST     = 2'd2;
    localparam logic [PHASE_W-1:0] PULSE_LAST       = 2'd1;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [MODE_W-1:0]  new_mode;
        logic [COLOR_W-1:0] color;
        logic [HALF_W-1:0]  blink_half_ticks;
        logic [CNT_W8-1:0]  blink_count;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [MODE_W-1:0] current_mode;
        logic              accepted;
    } t_out_item;

    typedef struct packed {
        logic [COLOR_W-1:0] pulse_color;
        logic [HOLD_W-1:0]  rainbow_step_ticks;
        logic [HOLD_W-1:0]  pulse_step_ticks;
    } t_cfg;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [MODE_W-1:0] push_mode;
    } t_hist_op;

    typedef struct packed {
        logic              empty;
        logic [MODE_W-1:0] top;
    } t_hist_stat;

    // Running effect state
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [PHASE_W-1:0] phase;
        logic [CHAN_W-1:0]  step;
        logic [HOLD_W-1:0]  hold;
        logic               lit;
        logic [WAIT_W-1:0]  wait_cnt;
        logic [CNT_W8-1:0]  left;
        logic [COLOR_W-1:0] shown;
    } t_fx;

endpackage

`default_nettype wire

@@ hw/rtl/rlec_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Command channel
interface rlec_in_if
    import rlec_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [MODE_W-1:0]  new_mode;
    logic [COLOR_W-1:0] color;
    logic [HALF_W-1:0]  blink_half_ticks;
    logic [CNT_W8-1:0]  blink_count;

    modport source (
        output valid, kind, new_mode, color, blink_half_ticks, blink_count,
        input  ready
    );
    modport sink (
        input  valid, kind, new_mode, color, blink_half_ticks, blink_count,
        output ready
    );
endinterface

// Result channel
interface rlec_out_if
    import rlec_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [MODE_W-1:0] current_mode;
    logic              accepted;

    modport source (
        output valid, red, green, blue, current_mode, accepted,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue, current_mode, accepted,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/rlec_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rlec_cfg
    import rlec_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_color        <= PULSE_COLOR_RST;
            r_cfg.rainbow_step_ticks <= RAINBOW_TICKS_RST;
            r_cfg.pulse_step_ticks   <= PULSE_TICKS_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PULSE_COLOR:   r_cfg.pulse_color        <= pwdata[COLOR_W-1:0];
                REG_RAINBOW_TICKS: r_cfg.rainbow_step_ticks <= pwdata[HOLD_W-1:0];
                REG_PULSE_TICKS:   r_cfg.pulse_step_ticks   <= pwdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_PULSE_COLOR:   prdata = PDATA_W'(r_cfg.pulse_color);
            REG_RAINBOW_TICKS: prdata = PDATA_W'(r_cfg.rainbow_step_ticks);
            REG_PULSE_TICKS:   prdata = PDATA_W'(r_cfg.pulse_step_ticks);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hw/rtl/rlec_hist.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Mode history: circular buffer, a push on a full stack overwrites the oldest
module rlec_hist
    import rlec_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_hist_op i_op,
    output t_hist_stat    o_stat
);

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);

    logic [MODE_W-1:0] r_stack [HISTORY_DEPTH];
    logic [IDX_W-1:0]  r_wp;
    logic [CNT_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wp_inc;

    // Top of stack sits just below the write pointer
    assign rd_idx = (r_wp == '0) ? LAST_IDX : r_wp - 1'b1;
    assign wp_inc = (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.top   = r_stack[rd_idx];

    // Pointer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_cnt <= '0;
        end else if (i_op.push) begin
            r_wp <= wp_inc;
            if (r_cnt != DEPTH_CNT) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end else if (i_op.pop) begin
            r_wp  <= rd_idx;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_stack[r_wp] <= i_op.push_mode;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rlec_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Effect engine: mode rules, ramps and blink timing, one item per enable
module rlec_core
    import rlec_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire t_in_item   i_item,
    input  wire t_cfg       i_cfg,
    input  wire t_hist_stat i_hist,
    output t_hist_op        o_hist_op,
    output t_out_item       o_result
);

    t_fx                r_fx;
    logic [COLOR_W-1:0] r_manual;
    logic [COLOR_W-1:0] r_bcol;
    logic [HALF_W-1:0]  r_bhalf;
    logic [CNT_W8-1:0]  r_btot;

    t_fx                n_fx;
    logic [COLOR_W-1:0] n_manual;
    logic [COLOR_W-1:0] n_bcol;
    logic [HALF_W-1:0]  n_bhalf;
    logic [CNT_W8-1:0]  n_btot;

    logic               ok;
    logic               go_prev;
    logic               flash;
    logic               do_push;
    logic [COLOR_W-1:0] c565;
    logic [HOLD_W-1:0]  hc;

    function automatic logic [COLOR_W-1:0] f_rainbow(
        input logic [PHASE_W-1:0] phase,
        input logic [CHAN_W-1:0]  step
    );
        logic [COLOR_W-1:0] c;
        case (phase)
            2'd0:    c = {RAMP_MAX - step, step, 8'd0};
            2'd1:    c = {8'd0, RAMP_MAX - step, step};
            default: c = {step, 8'd0, RAMP_MAX - step};
        endcase
        return c;
    endfunction

    // c*step/255 via reciprocal: (x + (x >> 8) + 1) >> 8 is exact for x = c*step, at most 255*255
    function automatic logic [CHAN_W-1:0] f_pulse_level(
        input logic [CHAN_W-1:0]  c,
        input logic [CHAN_W-1:0]  step,
        input logic [PHASE_W-1:0] phase
    );
        logic [15:0]       prod;
        logic [15:0]       sum;
        logic [CHAN_W-1:0] part;
        prod = 16'(c) * 16'(step);
        sum  = prod + 16'(prod[15:8]) + 16'd1;
        part = sum[15:8];
        return (phase == '0) ? part : c - part;
    endfunction

    function automatic t_fx f_enter(
        input t_fx                cur,
        input logic [MODE_W-1:0]  m,
        input logic [COLOR_W-1:0] mc,
        input logic [CNT_W8-1:0]  btot
    );
        t_fx fx;
        fx          = cur;
        fx.mode     = m;
        fx.phase    = '0;
        fx.step     = '0;
        fx.hold     = '0;
        fx.lit      = 1'b0;
        fx.wait_cnt = '0;
        case (m)
            MODE_MANUAL:  fx.shown = mc;
            MODE_RAINBOW: fx.shown = f_rainbow('0, '0);
            MODE_BLINK: begin
                fx.wait_cnt = BLINK_START_WAIT;
                fx.left     = btot;
                fx.shown    = '0;
            end
            default:      fx.shown = '0;
        endcase
        return fx;
    endfunction

    // One hold tick of a ramp; the step moves when the hold expires, the phase when the step wraps
    function automatic t_fx f_advance(
        input t_fx                cur,
        input logic [HOLD_W-1:0]  ticks,
        input logic [PHASE_W-1:0] last
    );
        t_fx               fx;
        logic [HOLD_W-1:0] len;
        logic [HOLD_W-1:0] cnt;
        fx  = cur;
        len = (ticks == '0) ? HOLD_W'(1) : ticks;
        cnt = cur.hold + 1'b1;
        if (cnt < len) begin
            fx.hold = cnt;
        end else begin
            fx.hold = '0;
            if (cur.step >= RAMP_LAST_STEP) begin
                fx.step  = '0;
                fx.phase = (cur.phase >= last) ? '0 : cur.phase + 1'b1;
            end else begin
                fx.step = cur.step + 1'b1;
            end
        end
        return fx;
    endfunction

    // RGB565 expanded to 8:8:8 with zero low bits
    assign c565 = {i_item.color[15:11], 3'd0, i_item.color[10:5], 2'd0,
                   i_item.color[4:0], 3'd0};

    // Next state for the item in the input register
    always_comb begin
        n_fx     = r_fx;
        n_manual = r_manual;
        n_bcol   = r_bcol;
        n_bhalf  = r_bhalf;
        n_btot   = r_btot;
        ok       = 1'b1;
        go_prev  = 1'b0;
        flash    = 1'b0;
        do_push  = 1'b0;
        hc       = r_fx.hold + 1'b1;

        case (i_item.kind)
            KIND_TICK: begin
                case (r_fx.mode)
                    MODE_RAINBOW: begin
                        n_fx = f_advance(r_fx, i_cfg.rainbow_step_ticks, RAINBOW_LAST);
                        n_fx.shown = f_rainbow(n_fx.phase, n_fx.step);
                    end
                    MODE_PULSING: begin
                        n_fx = f_advance(r_fx, i_cfg.pulse_step_ticks, PULSE_LAST);
                        n_fx.shown = {
                            f_pulse_level(i_cfg.pulse_color[23:16], n_fx.step, n_fx.phase),
                            f_pulse_level(i_cfg.pulse_color[15:8],  n_fx.step, n_fx.phase),
                            f_pulse_level(i_cfg.pulse_color[7:0],   n_fx.step, n_fx.phase)
                        };
                    end
                    MODE_BLINK: begin
                        if (r_fx.wait_cnt != '0) begin
                            // start-up wait before the first flash
                            n_fx.wait_cnt = r_fx.wait_cnt - 1'b1;
                            flash = (n_fx.wait_cnt == '0);
                        end else if (hc < HOLD_W'(r_bhalf)) begin
                            n_fx.hold = hc;
                        end else begin
                            n_fx.hold = '0;
                            if (r_fx.lit) begin
                                n_fx.lit   = 1'b0;
                                n_fx.shown = '0;
                            end else begin
                                if (r_fx.left != '0) begin
                                    n_fx.left = r_fx.left - 1'b1;
                                end
                                flash = 1'b1;
                            end
                        end
                        if (flash) begin
                            if (n_fx.left == '0 || r_bhalf == '0) begin
                                n_fx.left = '0;
                                go_prev   = 1'b1;
                            end else begin
                                n_fx.lit   = 1'b1;
                                n_fx.hold  = '0;
                                n_fx.shown = r_bcol;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            KIND_SET_MODE: begin
                if (i_item.new_mode > MODE_OVERRIDE || i_item.new_mode == r_fx.mode ||
                    r_fx.mode == MODE_BLINK || r_fx.mode == MODE_OVERRIDE) begin
                    ok = 1'b0;
                end else begin
                    do_push = 1'b1;
                    n_fx = f_enter(r_fx, i_item.new_mode, r_manual, r_btot);
                end
            end
            KIND_PREV_MODE: begin
                go_prev = 1'b1;
            end
            KIND_SET_COLOR, KIND_SET_565, KIND_OFF: begin
                if (r_fx.mode != MODE_MANUAL) begin
                    ok = 1'b0;
                end else begin
                    if (i_item.kind == KIND_SET_COLOR) begin
                        n_manual = i_item.color;
                    end else if (i_item.kind == KIND_SET_565) begin
                        n_manual = c565;
                    end else begin
                        n_manual = '0;
                    end
                    n_fx.shown = n_manual;
                end
            end
            KIND_OVERRIDE: begin
                if (r_fx.mode != MODE_OVERRIDE) begin
                    ok = 1'b0;
                end else begin
                    n_fx.shown = i_item.color;
                end
            end
            KIND_BLINK: begin
                if (r_fx.mode == MODE_BLINK) begin
                    ok = 1'b0;
                end else begin
                    n_bcol  = i_item.color;
                    n_bhalf = i_item.blink_half_ticks;
                    n_btot  = i_item.blink_count;
                    do_push = 1'b1;
                    n_fx = f_enter(r_fx, MODE_BLINK, r_manual, i_item.blink_count);
                end
            end
            default: ;
        endcase

        // Return to the previous mode; an empty history falls back to manual
        if (go_prev) begin
            if (i_hist.empty) begin
                n_fx.mode = MODE_MANUAL;
            end else begin
                n_fx = f_enter(n_fx, i_hist.top, n_manual, n_btot);
            end
        end
    end

    assign o_hist_op.push      = i_en && do_push;
    assign o_hist_op.pop       = i_en && go_prev && !i_hist.empty;
    assign o_hist_op.push_mode = r_fx.mode;

    assign o_result.red          = n_fx.shown[23:16];
    assign o_result.green        = n_fx.shown[15:8];
    assign o_result.blue         = n_fx.shown[7:0];
    assign o_result.current_mode = n_fx.mode;
    assign o_result.accepted     = ok;

    // State update on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx     <= '0;
            r_manual <= '0;
            r_bcol   <= '0;
            r_bhalf  <= '0;
            r_btot   <= '0;
        end else if (i_en) begin
            r_fx     <= n_fx;
            r_manual <= n_manual;
            r_bcol   <= n_bcol;
            r_bhalf  <= n_bhalf;
            r_btot   <= n_btot;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rgb_led_effect_mode_controller.sv @@
// Path: a command is captured in the input register and is processed into the result register
// once that register is empty or being read; the result register then offers the result on o_out.
// Throughput: one command or tick per cycle; a new transfer stalls only while the input
// register holds an item and the result register is full and not being read.
// Reset: i_rst_n is synchronous, active low; mode returns to manual, colors, ramps, blink state
// and history count clear, registers take their defaults; history entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_effect_mode_controller
    import rlec_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    rlec_in_if.sink                 i_in,
    rlec_out_if.source              o_out
);

    t_in_item   r_in;
    logic       r_in_vld;
    t_out_item  r_out;
    logic       r_out_vld;
    logic       adv;
    t_cfg       cfg;
    t_hist_op   hist_op;
    t_hist_stat hist_stat;
    t_out_item  result;

    // Process the held item when the result register is free or draining
    assign adv        = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.kind             <= i_in.kind;
            r_in.new_mode         <= i_in.new_mode;
            r_in.color            <= i_in.color;
            r_in.blink_half_ticks <= i_in.blink_half_ticks;
            r_in.blink_count      <= i_in.blink_count;
        end
    end

    rlec_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rlec_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (hist_op),
        .o_stat  (hist_stat)
    );

    rlec_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .i_hist    (hist_stat),
        .o_hist_op (hist_op),
        .o_result  (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.red          = r_out.red;
    assign o_out.green        = r_out.green;
    assign o_out.blue         = r_out.blue;
    assign o_out.current_mode = r_out.current_mode;
    assign o_out.accepted     = r_out.accepted;

endmodule

`default_nettype wire
